### hw/rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared constants, types and the divider step for the alpha-over blender.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

  localparam int PIX_W       = 8;
  localparam int NUM_W       = 24;   // s*u + d*v <= 255 * 65025
  localparam int DEN_W       = 16;   // u + v <= 65025
  localparam int Q_BITS      = 8;    // every quotient fits in 8 bits
  localparam int NLANE       = 3;    // red, green, blue
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIX_W-1:0] FULL = 8'd255;

  // x / 255 == (x * 32897) >> 23 for every 16-bit x
  localparam logic [DEN_W-1:0] RECIP_255   = 16'd32897;
  localparam int               RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    KIND_KEEP_DST,
    KIND_COPY_SRC,
    KIND_BLEND
  } kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pix_t;

  // Queue entry: res holds the finished pixel for copy cases and the
  // blended alpha for the blend case.
  typedef struct packed {
    logic [NLANE-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]            den;
    pix_t                        res;
    logic                        blend;
    logic                        changed;
  } qent_t;

  typedef struct packed {
    logic [NLANE-1:0][NUM_W-1:0]  rem;
    logic [NLANE-1:0][Q_BITS-1:0] q;
    logic [DEN_W-1:0]             den;
    pix_t                         res;
    logic                         blend;
    logic                         changed;
  } stage_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic             qbit;
  } step_t;

  // One restoring division step against a pre-shifted divisor
  function automatic step_t div_step(input logic [NUM_W-1:0] rem,
                                     input logic [NUM_W-1:0] dsh);
    step_t r;
    if (rem >= dsh) begin
      r.rem  = rem - dsh;
      r.qbit = 1'b1;
    end else begin
      r.rem  = rem;
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/aob_in_if.sv
// ----------------------------------------------------------------------------
// aob_in_if
// Input channel: one source and one destination RGBA8 pixel per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface aob_in_if;
  logic                       valid;
  logic                       ready;
  logic [aob_pkg::PIX_W-1:0]  src_red;
  logic [aob_pkg::PIX_W-1:0]  src_green;
  logic [aob_pkg::PIX_W-1:0]  src_blue;
  logic [aob_pkg::PIX_W-1:0]  src_alpha;
  logic [aob_pkg::PIX_W-1:0]  dst_red;
  logic [aob_pkg::PIX_W-1:0]  dst_green;
  logic [aob_pkg::PIX_W-1:0]  dst_blue;
  logic [aob_pkg::PIX_W-1:0]  dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );

  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/aob_out_if.sv
// ----------------------------------------------------------------------------
// aob_out_if
// Result channel: one composited RGBA8 pixel and a rewrite flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface aob_out_if;
  logic                       valid;
  logic                       ready;
  logic [aob_pkg::PIX_W-1:0]  out_red;
  logic [aob_pkg::PIX_W-1:0]  out_green;
  logic [aob_pkg::PIX_W-1:0]  out_blue;
  logic [aob_pkg::PIX_W-1:0]  out_alpha;
  logic                       dst_changed;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, dst_changed,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, dst_changed,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/aob_front.sv
// ----------------------------------------------------------------------------
// aob_front
// Accepts pixel pairs, classifies them and forms the blend weights,
// numerators, divisor and alpha ahead of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  aob_in_if.sink             in_ch,
  output aob_pkg::qent_t     push_data,
  output logic               push,
  input  wire logic          full
);

  logic                        a_valid_r, a_valid_nxt;
  aob_pkg::pix_t               a_src_r, a_dst_r;
  logic [aob_pkg::DEN_W-1:0]   a_u_r, a_v_r;
  aob_pkg::kind_t              a_kind_r, kind_in;

  logic                        take;
  logic [aob_pkg::DEN_W-1:0]   u_in, v_in;
  logic [aob_pkg::DEN_W-1:0]   den;
  logic [2*aob_pkg::DEN_W-1:0] alpha_prod;
  logic [aob_pkg::PIX_W-1:0]   blend_alpha;

  assign in_ch.ready = !a_valid_r || !full;
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = a_valid_r && !full;

  always_comb begin
    if (in_ch.src_alpha == '0) begin
      kind_in = aob_pkg::KIND_KEEP_DST;
    end else if (in_ch.src_alpha == aob_pkg::FULL || in_ch.dst_alpha == '0) begin
      kind_in = aob_pkg::KIND_COPY_SRC;
    end else begin
      kind_in = aob_pkg::KIND_BLEND;
    end
  end

  // u = sa*255, v = (255-sa)*da
  assign u_in = {in_ch.src_alpha, 8'd0} - aob_pkg::DEN_W'(in_ch.src_alpha);
  assign v_in = aob_pkg::DEN_W'(aob_pkg::FULL - in_ch.src_alpha) *
                aob_pkg::DEN_W'(in_ch.dst_alpha);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (take) begin
      a_valid_nxt = 1'b1;
    end else if (push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_src_r  <= '{in_ch.src_red, in_ch.src_green, in_ch.src_blue, in_ch.src_alpha};
      a_dst_r  <= '{in_ch.dst_red, in_ch.dst_green, in_ch.dst_blue, in_ch.dst_alpha};
      a_u_r    <= u_in;
      a_v_r    <= v_in;
      a_kind_r <= kind_in;
    end
  end

  assign den         = a_u_r + a_v_r;
  assign alpha_prod  = (2*aob_pkg::DEN_W)'(den) * (2*aob_pkg::DEN_W)'(aob_pkg::RECIP_255);
  assign blend_alpha = alpha_prod[aob_pkg::RECIP_SHIFT +: aob_pkg::PIX_W];

  always_comb begin
    push_data.num[0] = aob_pkg::NUM_W'(a_src_r.red) * aob_pkg::NUM_W'(a_u_r) +
                       aob_pkg::NUM_W'(a_dst_r.red) * aob_pkg::NUM_W'(a_v_r);
    push_data.num[1] = aob_pkg::NUM_W'(a_src_r.green) * aob_pkg::NUM_W'(a_u_r) +
                       aob_pkg::NUM_W'(a_dst_r.green) * aob_pkg::NUM_W'(a_v_r);
    push_data.num[2] = aob_pkg::NUM_W'(a_src_r.blue) * aob_pkg::NUM_W'(a_u_r) +
                       aob_pkg::NUM_W'(a_dst_r.blue) * aob_pkg::NUM_W'(a_v_r);
    push_data.den    = den;
    case (a_kind_r)
      aob_pkg::KIND_KEEP_DST: begin
        push_data.res     = a_dst_r;
        push_data.blend   = 1'b0;
        push_data.changed = 1'b0;
      end
      aob_pkg::KIND_COPY_SRC: begin
        push_data.res     = a_src_r;
        push_data.blend   = 1'b0;
        push_data.changed = 1'b1;
      end
      aob_pkg::KIND_BLEND: begin
        push_data.res       = a_src_r;
        push_data.res.alpha = blend_alpha;
        push_data.blend     = 1'b1;
        push_data.changed   = 1'b1;
      end
      default: begin
        push_data.res     = a_dst_r;
        push_data.blend   = 1'b0;
        push_data.changed = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/aob_queue.sv
// ----------------------------------------------------------------------------
// aob_queue
// Small FIFO decoupling the front end from the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_queue #(
  parameter int DEPTH = aob_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire aob_pkg::qent_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output aob_pkg::qent_t       pop_data,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  aob_pkg::qent_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

### hw/rtl/aob_back.sv
// ----------------------------------------------------------------------------
// aob_back
// Pipelined restoring divider, one quotient bit per stage on three colour
// lanes; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire aob_pkg::qent_t  pop_data,
  input  wire logic            empty,
  output logic                 pop,
  aob_out_if.source            out_ch
);

  localparam int NSTG = aob_pkg::Q_BITS;

  aob_pkg::stage_t  st_r  [NSTG];
  aob_pkg::stage_t  src_s [NSTG];
  aob_pkg::stage_t  nxt_s [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  src_vld;
  logic [NSTG-1:0]  leave;
  logic [NSTG-1:0]  open;

  // a stage may take a new item when empty or when its item moves on
  always_comb begin
    leave[NSTG-1] = vld_r[NSTG-1] && out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      leave[i] = vld_r[i] && (!vld_r[i+1] || leave[i+1]);
    end
    for (int i = 0; i < NSTG; i++) begin
      open[i] = !vld_r[i] || leave[i];
    end
  end

  assign pop = !empty && open[0];

  always_comb begin
    src_s[0].rem     = pop_data.num;
    src_s[0].q       = '0;
    src_s[0].den     = pop_data.den;
    src_s[0].res     = pop_data.res;
    src_s[0].blend   = pop_data.blend;
    src_s[0].changed = pop_data.changed;
    src_vld[0]       = !empty;
    for (int i = 1; i < NSTG; i++) begin
      src_s[i]   = st_r[i-1];
      src_vld[i] = vld_r[i-1];
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam int K = aob_pkg::Q_BITS - 1 - i;

    always_comb begin
      aob_pkg::step_t         stp;
      logic [aob_pkg::NUM_W-1:0] dsh;
      nxt_s[i] = src_s[i];
      dsh      = aob_pkg::NUM_W'(src_s[i].den) << K;
      for (int l = 0; l < aob_pkg::NLANE; l++) begin
        stp               = aob_pkg::div_step(src_s[i].rem[l], dsh);
        nxt_s[i].rem[l]   = stp.rem;
        nxt_s[i].q[l][K]  = stp.qbit;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (open[i]) begin
        vld_r[i] <= src_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (open[i] && src_vld[i]) begin
        st_r[i] <= nxt_s[i];
      end
    end
  end

  assign out_ch.valid       = vld_r[NSTG-1];
  assign out_ch.out_red     = st_r[NSTG-1].blend ? st_r[NSTG-1].q[0] : st_r[NSTG-1].res.red;
  assign out_ch.out_green   = st_r[NSTG-1].blend ? st_r[NSTG-1].q[1] : st_r[NSTG-1].res.green;
  assign out_ch.out_blue    = st_r[NSTG-1].blend ? st_r[NSTG-1].q[2] : st_r[NSTG-1].res.blue;
  assign out_ch.out_alpha   = st_r[NSTG-1].res.alpha;
  assign out_ch.dst_changed = st_r[NSTG-1].changed;

endmodule

`default_nettype wire

### hw/rtl/alpha_over_blend.sv
// ----------------------------------------------------------------------------
// alpha_over_blend
// Straight-alpha "over" compositing of one RGBA8 pixel pair per item.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock and returns one composited pixel per clock
// for as long as the result side keeps ready high. An accepted input passes
// through the front stage register, where the weights and numerators are
// formed, then through the queue, and then climbs the eight-stage divider,
// which resolves one quotient bit per stage for red, green and blue in
// parallel and whose last stage drives the outputs. The queue depth
// (QUEUE_DEPTH) sets how many items the front end can absorb while the result
// side stalls.
// Transparent-source items pass the destination through with dst_changed low.
`default_nettype none

module alpha_over_blend #(
  parameter int QUEUE_DEPTH = aob_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aob_in_if.sink     in_ch,
  aob_out_if.source  out_ch
);

  aob_pkg::qent_t  push_data;
  aob_pkg::qent_t  pop_data;
  logic            push, pop, full, empty;

  aob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  aob_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  aob_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel pairs into alpha_over_blend with random gaps and result-side
// stalls, predicts each composited pixel and compares it field by field.
// ----------------------------------------------------------------------------

module testbench;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 64;

  typedef struct packed {
    aob_pkg::pix_t src;
    aob_pkg::pix_t dst;
  } pair_t;

  typedef struct packed {
    aob_pkg::pix_t px;
    logic          changed;
  } blend_res_t;

  class blend_scoreboard;
    blend_res_t want_q[$];
    int         errors;
    int         seen;

    function new();
      errors = 0;
      seen   = 0;
    endfunction

    function automatic logic [7:0] mix(int unsigned s, int unsigned d,
                                       int unsigned u, int unsigned v);
      return 8'((s * u + d * v) / (u + v));
    endfunction

    function automatic blend_res_t composite(pair_t p);
      int unsigned u;
      int unsigned v;
      blend_res_t  r;
      if (p.src.alpha == 8'd0) begin
        r.px      = p.dst;
        r.changed = 1'b0;
      end else if (p.src.alpha == aob_pkg::FULL || p.dst.alpha == 8'd0) begin
        r.px      = p.src;
        r.changed = 1'b1;
      end else begin
        u = int'(p.src.alpha) * int'(aob_pkg::FULL);
        v = (int'(aob_pkg::FULL) - int'(p.src.alpha)) * int'(p.dst.alpha);
        r.px.red   = mix(p.src.red, p.dst.red, u, v);
        r.px.green = mix(p.src.green, p.dst.green, u, v);
        r.px.blue  = mix(p.src.blue, p.dst.blue, u, v);
        r.px.alpha = 8'((u + v) / int'(aob_pkg::FULL));
        r.changed  = 1'b1;
      end
      return r;
    endfunction

    function void note_pixel(pair_t p);
      want_q.push_back(composite(p));
    endfunction

    task report(string what, int got, int want);
      $display("result %0d: %0s got %0d, expected %0d", seen, what, got, want);
      errors++;
    endtask

    task check_pixel(blend_res_t got);
      blend_res_t want;
      if (want_q.size() == 0) begin
        report("item with nothing outstanding, red", got.px.red, -1);
      end else begin
        want = want_q.pop_front();
        if (got.px.red !== want.px.red)     report("red", got.px.red, want.px.red);
        if (got.px.green !== want.px.green) report("green", got.px.green, want.px.green);
        if (got.px.blue !== want.px.blue)   report("blue", got.px.blue, want.px.blue);
        if (got.px.alpha !== want.px.alpha) report("alpha", got.px.alpha, want.px.alpha);
        if (got.changed !== want.changed)   report("dst_changed", got.changed, want.changed);
      end
      seen++;
    endtask

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  aob_in_if  in_ch ();
  aob_out_if out_ch ();

  alpha_over_blend dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  blend_scoreboard sb;

  int idle_cycles;
  bit hold_req;
  bit pressing;
  int send_left;
  bit send_calm;
  int recv_left;
  bit recv_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mixes calm stretches (no waits) with stretches of random waits, picking each stretch at random
  function automatic int next_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(10, 40);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic pair_t mk(int sr, int sg, int sbl, int sa,
                               int dr, int dg, int db, int da);
    pair_t p;
    p.src = '{red: 8'(sr), green: 8'(sg), blue: 8'(sbl), alpha: 8'(sa)};
    p.dst = '{red: 8'(dr), green: 8'(dg), blue: 8'(db), alpha: 8'(da)};
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.src.red   = rand_chan();
    p.src.green = rand_chan();
    p.src.blue  = rand_chan();
    p.dst.red   = rand_chan();
    p.dst.green = rand_chan();
    p.dst.blue  = rand_chan();
    p.src.alpha = 8'($urandom_range(0, 255));
    p.dst.alpha = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: p.src.alpha = 8'd0;
      1: p.src.alpha = aob_pkg::FULL;
      2: p.dst.alpha = 8'd0;
      3: begin
        p.src.alpha = $urandom_range(0, 1) ? 8'd1 : 8'd254;
        p.dst.alpha = $urandom_range(0, 1) ? 8'd1 : aob_pkg::FULL;
      end
      default: ;
    endcase
    return p;
  endfunction

  task drive_pixel(pair_t p);
    int gap;
    gap = pressing ? 0 : next_wait(send_left, send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.src_red   <= p.src.red;
    in_ch.src_green <= p.src.green;
    in_ch.src_blue  <= p.src.blue;
    in_ch.src_alpha <= p.src.alpha;
    in_ch.dst_red   <= p.dst.red;
    in_ch.dst_green <= p.dst.green;
    in_ch.dst_blue  <= p.dst.blue;
    in_ch.dst_alpha <= p.dst.alpha;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Accept monitor and watchdog: inputs are noted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_pixel(mk(in_ch.src_red, in_ch.src_green, in_ch.src_blue,
                         in_ch.src_alpha, in_ch.dst_red, in_ch.dst_green,
                         in_ch.dst_blue, in_ch.dst_alpha));
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_pixel('{px: '{red: out_ch.out_red, green: out_ch.out_green,
                               blue: out_ch.out_blue, alpha: out_ch.out_alpha},
                         changed: out_ch.dst_changed});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = next_wait(recv_left, recv_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    pair_t directed[$];
    sb          = new();
    idle_cycles = 0;
    hold_req    = 1'b0;
    pressing    = 1'b0;
    send_left   = 0;
    send_calm   = 1'b0;
    recv_left   = 0;
    recv_calm   = 1'b0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.src_red   <= '0;
    in_ch.src_green <= '0;
    in_ch.src_blue  <= '0;
    in_ch.src_alpha <= '0;
    in_ch.dst_red   <= '0;
    in_ch.dst_green <= '0;
    in_ch.dst_blue  <= '0;
    in_ch.dst_alpha <= '0;
    out_ch.ready    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // transparent source keeps the destination
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(255, 255, 255, 0, 255, 255, 255, 255));
    directed.push_back(mk(17, 200, 90, 0, 3, 128, 250, 77));
    // opaque source replaces it
    directed.push_back(mk(0, 0, 0, 255, 255, 255, 255, 255));
    directed.push_back(mk(255, 255, 255, 255, 0, 0, 0, 0));
    directed.push_back(mk(12, 34, 56, 255, 78, 90, 123, 0));
    // transparent destination takes the source
    directed.push_back(mk(255, 0, 128, 1, 9, 9, 9, 0));
    directed.push_back(mk(0, 255, 1, 254, 200, 100, 50, 0));
    directed.push_back(mk(255, 255, 255, 128, 0, 0, 0, 0));
    // blend corners
    directed.push_back(mk(255, 255, 255, 1, 0, 0, 0, 1));
    directed.push_back(mk(0, 0, 0, 1, 255, 255, 255, 1));
    directed.push_back(mk(255, 0, 255, 1, 0, 255, 0, 255));
    directed.push_back(mk(0, 255, 0, 254, 255, 0, 255, 1));
    directed.push_back(mk(255, 255, 255, 254, 0, 0, 0, 255));
    directed.push_back(mk(0, 0, 0, 254, 255, 255, 255, 255));
    directed.push_back(mk(128, 128, 128, 128, 128, 128, 128, 128));
    directed.push_back(mk(255, 255, 255, 128, 255, 255, 255, 255));
    directed.push_back(mk(1, 2, 3, 2, 254, 253, 252, 254));
    directed.push_back(mk(170, 85, 170, 85, 85, 170, 85, 170));
    foreach (directed[i]) drive_pixel(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long result-side hold while items keep coming back to back
      if (i == 400) begin
        hold_req = 1'b1;
        pressing = 1'b1;
      end
      if (i == 480) pressing = 1'b0;
      drive_pixel(rand_pair());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/aob_pkg.sv
hw/rtl/aob_in_if.sv
hw/rtl/aob_out_if.sv
hw/rtl/aob_front.sv
hw/rtl/aob_queue.sv
hw/rtl/aob_back.sv
hw/rtl/alpha_over_blend.sv
tb/sv/testbench.sv
